// ----- hdl/assert_macros.svh -----
// -----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks shared by the RTL; the enclosing module provides
// clk and arst_n.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- hdl/dmc_pkg.sv -----
// -----------------------------------------------------------------------------
// dmc_pkg
// Shared constants for the direct-mapped cache tag checker.
// -----------------------------------------------------------------------------
package dmc_pkg;

	localparam int ADDR_W          = 32;
	localparam int CNT_W           = 32;
	localparam int INDEX_BITS_DEF  = 14;
	localparam int TAG_BITS_DEF    = 16;
	localparam int OFFSET_BITS_DEF = 2;

endpackage

// ----- hdl/dmc_if.sv -----
// -----------------------------------------------------------------------------
// dmc channel interfaces
// Valid/ready channels for lookup requests and lookup results.
// -----------------------------------------------------------------------------
interface dmc_req_if
	import dmc_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] address;

	modport source (output valid, output address, input ready);
	modport sink   (input valid, input address, output ready);
endinterface

interface dmc_rsp_if
	import dmc_pkg::*;
#(
	parameter int TAG_BITS   = TAG_BITS_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic                  hit;
	logic [TAG_BITS-1:0]   tag;
	logic [INDEX_BITS-1:0] line_index;
	logic [CNT_W-1:0]      hit_total;
	logic [CNT_W-1:0]      miss_total;

	modport source (output valid, output hit, output tag, output line_index,
		output hit_total, output miss_total, input ready);
	modport sink   (input valid, input hit, input tag, input line_index,
		input hit_total, input miss_total, output ready);
endinterface

// ----- hdl/direct_mapped_cache_tag_check.sv -----
// -----------------------------------------------------------------------------
// direct_mapped_cache_tag_check
// Stages: RAM read registered into s1, tag compare in s1, result register.
// Throughput: one lookup per cycle unless the result side stalls; a miss written back
// at the same edge as the next read is forwarded from a bypass register.
// Reset: counters clear at once; valid RAM is swept one line a cycle over all
// 2**INDEX_BITS lines (16384 by default), request ready low until the sweep is done.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module direct_mapped_cache_tag_check
	import dmc_pkg::*;
#(
	parameter int INDEX_BITS  = INDEX_BITS_DEF,
	parameter int TAG_BITS    = TAG_BITS_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	dmc_req_if.sink   request,
	dmc_rsp_if.source result
);

	localparam int EXT_W = 2 * ADDR_W + 64;

	logic [EXT_W-1:0]      addr_ext;
	logic [INDEX_BITS-1:0] in_index;
	logic [TAG_BITS-1:0]   in_tag;
	logic                  in_fire;

	logic                  s1_valid_q;
	logic [INDEX_BITS-1:0] index_s1;
	logic [TAG_BITS-1:0]   tag_s1;
	logic [TAG_BITS-1:0]   rd_tag_s1;
	logic                  rd_valid_s1;
	logic                  s1_fire;
	logic                  fwd_match;
	logic                  hit_s1;

	logic                  fwd_valid_q;
	logic [INDEX_BITS-1:0] fwd_index_q;
	logic [TAG_BITS-1:0]   fwd_tag_q;

	logic                  clearing_q;
	logic [INDEX_BITS-1:0] clr_idx_q;

	logic [CNT_W-1:0]      hit_cnt_q;
	logic [CNT_W-1:0]      miss_cnt_q;

	logic                  out_valid_q;
	logic                  out_hit_q;
	logic [TAG_BITS-1:0]   out_tag_q;
	logic [INDEX_BITS-1:0] out_index_q;
	logic [CNT_W-1:0]      out_hits_q;
	logic [CNT_W-1:0]      out_misses_q;

	logic                  miss_wr;
	logic                  vld_we;
	logic [INDEX_BITS-1:0] vld_waddr;
	logic [0:0]            vld_wdata;
	logic [0:0]            vld_rdata;

	// address split; fields past bit 31 read as zero
	assign addr_ext = {{(EXT_W-ADDR_W){1'b0}}, request.address};
	assign in_index = INDEX_BITS'(addr_ext >> OFFSET_BITS);
	assign in_tag   = TAG_BITS'(addr_ext >> (OFFSET_BITS + INDEX_BITS));

	assign s1_fire       = s1_valid_q && (!out_valid_q || result.ready);
	assign request.ready = !clearing_q && (!s1_valid_q || s1_fire);
	assign in_fire       = request.valid && request.ready;

	// a miss written at the edge that read this entry is not in the RAM data
	assign fwd_match   = fwd_valid_q && (fwd_index_q == index_s1);
	assign rd_valid_s1 = vld_rdata[0];
	assign hit_s1      = fwd_match ? (fwd_tag_q == tag_s1)
	                               : (rd_valid_s1 && (rd_tag_s1 == tag_s1));
	assign miss_wr     = s1_fire && !hit_s1;

	assign vld_we    = clearing_q || miss_wr;
	assign vld_waddr = clearing_q ? clr_idx_q : index_s1;
	assign vld_wdata = clearing_q ? 1'b0 : 1'b1;

	dmc_ram #(
		.WIDTH     (TAG_BITS),
		.ADDR_BITS (INDEX_BITS)
	) u_tag_ram (
		.clk   (clk),
		.we    (miss_wr),
		.waddr (index_s1),
		.wdata (tag_s1),
		.re    (in_fire),
		.raddr (in_index),
		.rdata (rd_tag_s1)
	);

	dmc_ram #(
		.WIDTH     (1),
		.ADDR_BITS (INDEX_BITS)
	) u_valid_ram (
		.clk   (clk),
		.we    (vld_we),
		.waddr (vld_waddr),
		.wdata (vld_wdata),
		.re    (in_fire),
		.raddr (in_index),
		.rdata (vld_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == {INDEX_BITS{1'b1}}) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				s1_valid_q  <= 1'b1;
				fwd_valid_q <= miss_wr;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			index_s1    <= in_index;
			tag_s1      <= in_tag;
			fwd_index_q <= index_s1;
			fwd_tag_q   <= tag_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else if (s1_fire) begin
			if (hit_s1) begin
				hit_cnt_q <= hit_cnt_q + 1'b1;
			end else begin
				miss_cnt_q <= miss_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_hit_q    <= hit_s1;
			out_tag_q    <= tag_s1;
			out_index_q  <= index_s1;
			out_hits_q   <= hit_s1 ? hit_cnt_q + 1'b1 : hit_cnt_q;
			out_misses_q <= hit_s1 ? miss_cnt_q : miss_cnt_q + 1'b1;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.hit        = out_hit_q;
	assign result.tag        = out_tag_q;
	assign result.line_index = out_index_q;
	assign result.hit_total  = out_hits_q;
	assign result.miss_total = out_misses_q;

	`ASSERT_SAME(a_no_req_while_clearing, clearing_q, !request.ready)
	`ASSERT_NEXT(a_one_count_per_lookup, s1_fire,
		(hit_cnt_q + miss_cnt_q) == CNT_W'($past(hit_cnt_q) + $past(miss_cnt_q) + 1'b1))
	`ASSERT_NEXT(a_result_matches_counts, s1_fire,
		out_valid_q && (out_hits_q == hit_cnt_q) && (out_misses_q == miss_cnt_q))
	`ASSERT_NEXT(a_req_enters_stage, in_fire, s1_valid_q)

endmodule

// ----- hdl/dmc_ram.sv -----
// -----------------------------------------------------------------------------
// dmc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// -----------------------------------------------------------------------------
module dmc_ram #(
	parameter int WIDTH     = 16,
	parameter int ADDR_BITS = 14
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [2**ADDR_BITS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read during write to the same entry returns the old contents
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Testbench for direct_mapped_cache_tag_check: drives lookup addresses,
// predicts hit/miss, tag, line index and running counters from a local copy of
// the tag and valid stores, and checks every result transaction in order.
// -----------------------------------------------------------------------------
module tb_top
	import dmc_pkg::*;
();

	localparam int LINES = 1 << INDEX_BITS_DEF;

	typedef struct packed {
		logic                      hit;
		logic [TAG_BITS_DEF-1:0]   tag;
		logic [INDEX_BITS_DEF-1:0] line_index;
		logic [CNT_W-1:0]          hit_total;
		logic [CNT_W-1:0]          miss_total;
	} lookup_result_t;

	logic clk;
	logic arst_n;

	dmc_req_if request_ch ();
	dmc_rsp_if result_ch ();

	direct_mapped_cache_tag_check DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request_ch),
		.result  (result_ch)
	);

	// local copy of the cache state
	logic [TAG_BITS_DEF-1:0] stored_tag [LINES];
	logic                    line_valid [LINES];
	logic [CNT_W-1:0]        hits_so_far;
	logic [CNT_W-1:0]        misses_so_far;

	lookup_result_t          pending_results [$];
	int                      mismatches;
	bit                      idle_on;
	int                      hold_left;
	logic [TAG_BITS_DEF-1:0] hot_tags [4];

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void predict_lookup(input logic [ADDR_W-1:0] addr);
		lookup_result_t            r;
		logic [INDEX_BITS_DEF-1:0] ln;
		logic [TAG_BITS_DEF-1:0]   tg;
		ln = addr[OFFSET_BITS_DEF +: INDEX_BITS_DEF];
		tg = addr[OFFSET_BITS_DEF + INDEX_BITS_DEF +: TAG_BITS_DEF];
		r.hit = line_valid[ln] && (stored_tag[ln] == tg);
		if (r.hit) begin
			hits_so_far = hits_so_far + 1'b1;
		end else begin
			misses_so_far  = misses_so_far + 1'b1;
			stored_tag[ln] = tg;
			line_valid[ln] = 1'b1;
		end
		r.tag        = tg;
		r.line_index = ln;
		r.hit_total  = hits_so_far;
		r.miss_total = misses_so_far;
		pending_results.push_back(r);
	endfunction

	// one request transaction, with an optional idle burst in front of it
	task automatic send_lookup(input logic [ADDR_W-1:0] addr);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			request_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		request_ch.valid   <= 1'b1;
		request_ch.address <= addr;
		@(posedge clk);
		while (!request_ch.ready) @(posedge clk);
		predict_lookup(addr);
	endtask

	task automatic drop_request();
		request_ch.valid <= 1'b0;
	endtask

	// mostly a small working set so lines get hits and conflict evictions
	function automatic logic [ADDR_W-1:0] pick_address();
		logic [INDEX_BITS_DEF-1:0] ln;
		logic [ADDR_W-1:0]         a;
		a = $urandom;
		if ($urandom_range(0, 9) < 2)
			return a;
		case ($urandom_range(0, 3))
			0, 1: ln = INDEX_BITS_DEF'($urandom_range(0, 31));
			2: ln = INDEX_BITS_DEF'(LINES - 1) - INDEX_BITS_DEF'($urandom_range(0, 31));
			default: ln = INDEX_BITS_DEF'($urandom);
		endcase
		a[OFFSET_BITS_DEF + INDEX_BITS_DEF +: TAG_BITS_DEF] =
			hot_tags[2'($urandom_range(0, 3))];
		a[OFFSET_BITS_DEF +: INDEX_BITS_DEF] = ln;
		return a;
	endfunction

	// result side: stall bursts, long hold-off on request, in-order checking
	initial begin
		lookup_result_t exp_r;
		int             stall_left;
		stall_left     = 0;
		hold_left      = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				if (pending_results.size() == 0) begin
					$error("result transaction with no lookup pending");
					mismatches++;
				end else begin
					exp_r = pending_results.pop_front();
					if (result_ch.hit !== exp_r.hit) begin
						$error("hit: expected %0d, actual %0d", exp_r.hit, result_ch.hit);
						mismatches++;
					end
					if (result_ch.tag !== exp_r.tag) begin
						$error("tag: expected %h, actual %h", exp_r.tag, result_ch.tag);
						mismatches++;
					end
					if (result_ch.line_index !== exp_r.line_index) begin
						$error("line_index: expected %h, actual %h",
							exp_r.line_index, result_ch.line_index);
						mismatches++;
					end
					if (result_ch.hit_total !== exp_r.hit_total) begin
						$error("hit_total: expected %0d, actual %0d",
							exp_r.hit_total, result_ch.hit_total);
						mismatches++;
					end
					if (result_ch.miss_total !== exp_r.miss_total) begin
						$error("miss_total: expected %0d, actual %0d",
							exp_r.miss_total, result_ch.miss_total);
						mismatches++;
					end
				end
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				result_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 2);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	task automatic test_directed();
		logic [ADDR_W-1:0] seq [$];
		idle_on = 1'b0;
		// back-to-back on one line exercises the write-back bypass
		seq = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0003, 32'h0000_0001,
			32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'hFFFF_0000, 32'h0000_0000,
			32'h0000_FFFC, 32'hFFFF_FFFE, 32'h0001_0000, 32'h0001_0002,
			32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h8000_8000,
			32'h7FFF_7FFF, 32'h8000_8001, 32'h5555_AAAA, 32'hAAAA_5555,
			32'h5555_AAAB, 32'h0000_0004, 32'h0000_0008};
		foreach (seq[i])
			send_lookup(seq[i]);
	endtask

	task automatic test_random_mix();
		idle_on = 1'b1;
		repeat (560)
			send_lookup(pick_address());
	endtask

	// receiver holds off long enough for the block to fill and stall requests
	task automatic test_backpressure();
		idle_on   = 1'b1;
		hold_left = 300;
		repeat (60)
			send_lookup(pick_address());
	endtask

	// sender pauses until every result is back, then resumes
	task automatic test_drain_pause();
		drop_request();
		while (pending_results.size() != 0) @(posedge clk);
		idle_on = 1'b1;
		repeat (60)
			send_lookup(pick_address());
	endtask

	task automatic test_streaming();
		idle_on = 1'b0;
		repeat (250)
			send_lookup(pick_address());
	endtask

	initial begin
		arst_n             = 1'b0;
		request_ch.valid   = 1'b0;
		request_ch.address = '0;
		mismatches         = 0;
		idle_on            = 1'b0;
		hits_so_far        = '0;
		misses_so_far      = '0;
		foreach (line_valid[i]) begin
			line_valid[i] = 1'b0;
			stored_tag[i] = '0;
		end
		hot_tags[0] = '0;
		hot_tags[1] = '1;
		hot_tags[2] = TAG_BITS_DEF'($urandom);
		hot_tags[3] = TAG_BITS_DEF'($urandom);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_mix();
		test_backpressure();
		test_drain_pause();
		test_streaming();

		drop_request();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#3ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/dmc_pkg.sv
hdl/dmc_if.sv
hdl/dmc_ram.sv
hdl/direct_mapped_cache_tag_check.sv
tb/tb_top.sv
